FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with synchronous reset disable
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication shorthand on the default clock and reset names
`define ASSERT_IMP(lbl, ante, cons, msg) \
  `ASSERT_CLK(lbl, clk, rst, (ante) |-> (cons), msg)

`endif

FILE: rtl/aus_pkg.sv
// ----------------------------------------------------------------------------
// aus_pkg
// Types, constants and helpers of the Annex-B access unit splitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package aus_pkg;

  // Width of the internal byte position counters
  localparam int OFFSET_BITS = 32;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  typedef logic [OFFSET_BITS-1:0] pos_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_UNIT       = 2'd0,
    KIND_END_UNITS  = 2'd1,
    KIND_END_EMPTY  = 2'd2
  } kind_t;

  // Stream constants
  localparam logic [7:0] START_BYTE    = 8'h01;
  localparam logic [7:0] ZERO_BYTE     = 8'h00;
  localparam logic [4:0] NAL_TYPE_MASK = 5'h1f;
  localparam logic [4:0] NAL_TYPE_AUD  = 5'd9;

  // One result beat
  typedef struct packed {
    kind_t       kind;
    logic [31:0] unit_offset;
    logic [31:0] unit_length;
    logic        last_result;
  } result_t;

  // Cut or extend a position to the 32-bit output field
  function automatic logic [31:0] fit32(pos_t v);
    logic [63:0] w;
    w = 64'(v);
    return w[31:0];
  endfunction

endpackage

FILE: rtl/annexb_access_unit_splitter.sv
// ----------------------------------------------------------------------------
// annexb_access_unit_splitter
// Splits an Annex-B byte stream into access units and reports each one.
// ----------------------------------------------------------------------------
// Takes one stream byte per beat and accepts a byte every clock while s_tready is high. Each byte is
// scanned in the cycle it is accepted and its results (none, one or two) land
// in a four-beat result queue that feeds the master side in order. s_tready
// falls only while that queue holds more than two beats, that is while the
// master side stalls; with m_tready held high the block sustains one byte per
// cycle. After the last byte the state returns to reset and the next byte
// starts a new stream at offset 0.
`timescale 1ns / 1ps

module annexb_access_unit_splitter
  import aus_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [31:0] unit_offset, [63:32] unit_length
  output logic [1:0]  m_tuser,   // [1:0] kind
  output logic        m_tlast    // last_result
);

  // Scanner state
  pos_t        byte_position, byte_position_next;
  logic [23:0] recent_bytes, recent_bytes_next;
  logic [1:0]  bytes_since_code, bytes_since_code_next;
  pos_t        candidate_pos, candidate_pos_next;
  logic        header_expected, header_expected_next;
  logic        nal_open, nal_open_next;
  logic        nal_is_delimiter, nal_is_delimiter_next;
  logic        unit_open, unit_open_next;
  pos_t        unit_start, unit_start_next;
  pos_t        unit_end, unit_end_next;
  logic        any_unit_emitted, any_unit_emitted_next;

  // Result queue
  result_t              queue [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [QPTR_BITS:0]   count;

  logic    accept, pop;
  logic    push_a, push_b;
  result_t res_a, res_b;

  assign accept   = s_tvalid && s_tready;
  assign pop      = m_tvalid && m_tready;
  assign s_tready = (count <= (QPTR_BITS+1)'(QUEUE_DEPTH - 2));

  // Scan one byte: header handling, start code search, end of stream
  always_comb begin
    logic [4:0] hdr_type;
    logic       is_aud;
    logic       emit_aud;
    logic       emit_end;
    logic       found;
    pos_t       pos1;
    pos_t       end1;
    pos_t       end2;
    logic       open1;
    pos_t       start1;
    logic       delim1;
    logic       nopen1;
    logic       any1;
    logic       any2;

    hdr_type = s_tdata[4:0] & NAL_TYPE_MASK;
    is_aud   = (hdr_type == NAL_TYPE_AUD);
    pos1     = byte_position + pos_t'(1);

    // Close the previous NAL and open the new one on its header byte
    end1     = (header_expected && nal_open && !nal_is_delimiter) ? candidate_pos : unit_end;
    emit_aud = header_expected && is_aud && unit_open;
    open1    = header_expected ? !is_aud : unit_open;
    start1   = (header_expected && !is_aud && !unit_open) ? candidate_pos : unit_start;
    delim1   = header_expected ? is_aud : nal_is_delimiter;
    nopen1   = header_expected || nal_open;
    any1     = any_unit_emitted || emit_aud;

    // Look for a start code ending in this byte
    found = (s_tdata == START_BYTE) && (bytes_since_code >= 2'd2)
         && (recent_bytes[15:8] == ZERO_BYTE) && (recent_bytes[7:0] == ZERO_BYTE);
    candidate_pos_next = candidate_pos;
    if (found) begin
      if ((bytes_since_code == 2'd3) && (recent_bytes[23:16] == ZERO_BYTE)) begin
        candidate_pos_next = byte_position - pos_t'(3);
      end else begin
        candidate_pos_next = byte_position - pos_t'(2);
      end
    end

    // End of stream: current NAL runs to the final byte
    end2     = (nopen1 && !delim1) ? pos1 : end1;
    emit_end = s_tlast && open1;
    any2     = any1 || emit_end;

    // Build the results
    res_a             = '0;
    res_a.kind        = KIND_UNIT;
    res_a.last_result = !s_tlast;
    if (emit_aud) begin
      res_a.unit_offset = fit32(unit_start);
      res_a.unit_length = fit32(end1 - unit_start);
    end else begin
      res_a.unit_offset = fit32(start1);
      res_a.unit_length = fit32(end2 - start1);
    end
    res_b             = '0;
    res_b.kind        = any2 ? KIND_END_UNITS : KIND_END_EMPTY;
    res_b.last_result = 1'b1;
    push_a = accept && (emit_aud || emit_end);
    push_b = accept && s_tlast;

    // Next state
    header_expected_next  = found;
    recent_bytes_next     = {recent_bytes[15:0], s_tdata};
    bytes_since_code_next = (bytes_since_code == 2'd3) ? 2'd3 : bytes_since_code + 2'd1;
    byte_position_next    = pos1;
    nal_open_next         = nopen1;
    nal_is_delimiter_next = delim1;
    unit_open_next        = open1;
    unit_start_next       = start1;
    unit_end_next         = end1;
    any_unit_emitted_next = any1;

    // Return to reset after the final byte
    if (s_tlast) begin
      header_expected_next  = 1'b0;
      recent_bytes_next     = '0;
      bytes_since_code_next = '0;
      byte_position_next    = '0;
      candidate_pos_next    = '0;
      nal_open_next         = 1'b0;
      nal_is_delimiter_next = 1'b0;
      unit_open_next        = 1'b0;
      unit_start_next       = '0;
      unit_end_next         = '0;
      any_unit_emitted_next = 1'b0;
    end
  end

  // Advance scanner state on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= '0;
      recent_bytes     <= '0;
      bytes_since_code <= '0;
      candidate_pos    <= '0;
      header_expected  <= 1'b0;
      nal_open         <= 1'b0;
      nal_is_delimiter <= 1'b0;
      unit_open        <= 1'b0;
      unit_start       <= '0;
      unit_end         <= '0;
      any_unit_emitted <= 1'b0;
    end else if (accept) begin
      byte_position    <= byte_position_next;
      recent_bytes     <= recent_bytes_next;
      bytes_since_code <= bytes_since_code_next;
      candidate_pos    <= candidate_pos_next;
      header_expected  <= header_expected_next;
      nal_open         <= nal_open_next;
      nal_is_delimiter <= nal_is_delimiter_next;
      unit_open        <= unit_open_next;
      unit_start       <= unit_start_next;
      unit_end         <= unit_end_next;
      any_unit_emitted <= any_unit_emitted_next;
    end
  end

  // Write up to two results into the queue
  always_ff @(posedge clk) begin
    if (push_a) begin
      queue[wr_ptr] <= res_a;
      if (push_b) begin
        queue[wr_ptr + QPTR_BITS'(1)] <= res_b;
      end
    end else if (push_b) begin
      queue[wr_ptr] <= res_b;
    end
  end

  // Track queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_BITS'(push_a) + QPTR_BITS'(push_b);
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_BITS'(1);
      end
      count <= count + (QPTR_BITS+1)'(push_a) + (QPTR_BITS+1)'(push_b)
             - (QPTR_BITS+1)'(pop);
    end
  end

  // Drive the head beat
  assign m_tvalid = (count != '0);
  assign m_tdata  = {queue[rd_ptr].unit_length, queue[rd_ptr].unit_offset};
  assign m_tuser  = queue[rd_ptr].kind;
  assign m_tlast  = queue[rd_ptr].last_result;

endmodule

FILE: rtl/aus_checker.sv
// ----------------------------------------------------------------------------
// aus_checker
// Port-level checks of the Annex-B access unit splitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module aus_checker
  import aus_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [7:0]  s_tdata,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);

  // Hold a stalled result beat
  `ASSERT_CLK(a_hold_valid, clk, rst, m_tvalid && !m_tready |=> m_tvalid, "result beat dropped")

  // A status beat always closes its byte's results
  `ASSERT_IMP(a_status_last, m_tvalid && (m_tuser != KIND_UNIT), m_tlast, "status beat not last")

  // A status beat carries no offset or length
  `ASSERT_IMP(a_status_zero, m_tvalid && (m_tuser != KIND_UNIT), m_tdata == '0, "status nonzero")

  // A unit that is not last is followed at once by its status beat
  `ASSERT_CLK(a_status_follows, clk, rst, m_tvalid && m_tready && (m_tuser == KIND_UNIT) && !m_tlast |=> m_tvalid && (m_tuser != KIND_UNIT), "missing status")

endmodule

bind annexb_access_unit_splitter aus_checker u_aus_checker (.*);

FILE: sim/annexb_access_unit_splitter_test.sv
// ----------------------------------------------------------------------------
// annexb_access_unit_splitter_test
// Self-checking bench for the Annex-B access unit splitter. Streams of start
// codes, NAL headers and payload bytes go in; each result beat is compared
// field by field with a software model of the splitter, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module annexb_access_unit_splitter_test;
  import aus_pkg::*;

  localparam int RUN_BYTES   = 1000;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 10;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [7:0] data_byte
  logic        s_tlast;   // last_byte
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;   // [31:0] unit_offset, [63:32] unit_length
  logic [1:0]  m_tuser;   // [1:0] kind
  logic        m_tlast;   // last_result

  // Tracks the stream the way the splitter does and holds the result beats
  // still owed by the block.
  class access_unit_tracker;
    result_t     owed_units[$];
    int          mismatches;
    pos_t        byte_pos;
    logic [23:0] recent;
    logic [1:0]  seen;
    pos_t        code_pos;
    bit          header_wait;
    bit          nal_open;
    bit          nal_aud;
    bit          unit_open;
    pos_t        unit_start;
    pos_t        unit_end;
    bit          any_unit;

    function new();
      mismatches = 0;
      clear_stream();
    endfunction

    function void clear_stream();
      byte_pos    = '0;
      recent      = '0;
      seen        = '0;
      code_pos    = '0;
      header_wait = 1'b0;
      nal_open    = 1'b0;
      nal_aud     = 1'b0;
      unit_open   = 1'b0;
      unit_start  = '0;
      unit_end    = '0;
      any_unit    = 1'b0;
    endfunction

    function result_t beat(kind_t k, pos_t off, pos_t len);
      result_t r;
      r.kind        = k;
      r.unit_offset = 32'(off);
      r.unit_length = 32'(len);
      r.last_result = 1'b0;
      return r;
    endfunction

    function int owed();
      return owed_units.size();
    endfunction

    // Advance the stream model by one accepted byte
    function void take_byte(logic [7:0] b, bit last);
      result_t res[2];
      int      n;
      pos_t    p;
      pos_t    c;
      n = 0;
      p = byte_pos;

      // Header byte of the code found earlier: open, extend or close a unit
      if (header_wait) begin
        c = code_pos;
        header_wait = 1'b0;
        if (nal_open && !nal_aud) unit_end = c;
        if ((b[4:0] & NAL_TYPE_MASK) == NAL_TYPE_AUD) begin
          if (unit_open) begin
            res[n] = beat(KIND_UNIT, unit_start, unit_end - unit_start);
            n++;
            any_unit = 1'b1;
            unit_open = 1'b0;
          end
          nal_aud = 1'b1;
        end else begin
          if (!unit_open) begin
            unit_open = 1'b1;
            unit_start = c;
          end
          nal_aud = 1'b0;
        end
        nal_open = 1'b1;
      end

      // Start code ends on this byte: it began two or three bytes back
      if (b == START_BYTE && seen >= 2 && recent[15:0] == {ZERO_BYTE, ZERO_BYTE}) begin
        c = p - 2;
        if (seen == 3 && recent[23:16] == ZERO_BYTE) c = p - 3;
        code_pos = c;
        header_wait = 1'b1;
      end

      recent = {recent[15:0], b};
      if (seen < 3) seen++;
      byte_pos = p + 1;

      // End of stream: flush the open unit, then the status beat
      if (last) begin
        if (nal_open && !nal_aud) unit_end = byte_pos;
        if (unit_open) begin
          res[n] = beat(KIND_UNIT, unit_start, unit_end - unit_start);
          n++;
          any_unit = 1'b1;
        end
        res[n] = beat(any_unit ? KIND_END_UNITS : KIND_END_EMPTY, '0, '0);
        n++;
        clear_stream();
      end

      for (int i = 0; i < n; i++) begin
        res[i].last_result = (i == n - 1);
        owed_units.push_back(res[i]);
      end
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("error at %0t: %s got %0h, want %0h", $realtime, what, got, want);
      mismatches++;
    endtask

    // Compare one result beat with the oldest one owed
    task match_result(logic [1:0] k, logic [31:0] off, logic [31:0] len, logic lst);
      result_t w;
      if (owed_units.size() == 0) begin
        report("unexpected beat, kind", 32'(k), '0);
      end else begin
        w = owed_units.pop_front();
        if (k !== w.kind) report("kind", 32'(k), 32'(w.kind));
        if (off !== w.unit_offset) report("unit_offset", off, w.unit_offset);
        if (len !== w.unit_length) report("unit_length", len, w.unit_length);
        if (lst !== w.last_result) report("last_result", 32'(lst), 32'(w.last_result));
      end
    endtask
  endclass

  access_unit_tracker tracker;
  int idle_pct;
  int stall_pct;
  int bytes_sent;
  int cycle_count;

  annexb_access_unit_splitter uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver side: stall at random
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Check result beats; stop on a hung run
  always @(posedge clk) begin
    if (!rst) begin
      cycle_count++;
      if (m_tvalid && m_tready) begin
        tracker.match_result(m_tuser, m_tdata[31:0], m_tdata[63:32], m_tlast);
      end
      if (cycle_count > CYCLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Send one byte beat, idling first at random; returns at the accepting edge
  task send_byte(input logic [7:0] b, input bit last);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    tracker.take_byte(b, last);
    bytes_sent++;
  endtask

  task send_run(input logic [7:0] q[$], input bit end_stream);
    foreach (q[i]) send_byte(q[i], end_stream && (i == q.size() - 1));
  endtask

  // Hold the sender until every owed beat has come back
  task drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (tracker.owed() != 0);
  endtask

  function logic [7:0] payload_byte();
    return ($urandom_range(4) == 0) ? ZERO_BYTE : 8'($urandom_range(255));
  endfunction

  // Well-formed stream: start codes, headers, payload, then the end flag
  task send_stream();
    logic [7:0] q[$];
    logic [7:0] hdr;
    q = {};
    repeat ($urandom_range(2)) q.push_back(8'($urandom_range(255)));
    repeat ($urandom_range(1, 5)) begin
      if ($urandom_range(1)) q.push_back(ZERO_BYTE);
      q.push_back(ZERO_BYTE);
      q.push_back(ZERO_BYTE);
      q.push_back(START_BYTE);
      hdr = 8'($urandom_range(255));
      if ($urandom_range(3) == 0) hdr[4:0] = NAL_TYPE_AUD;
      q.push_back(hdr);
      repeat ($urandom_range(6)) q.push_back(payload_byte());
    end
    // Now and then end on a start code with no header
    if ($urandom_range(9) == 0) q = {q, ZERO_BYTE, ZERO_BYTE, START_BYTE};
    send_run(q, 1'b1);
  endtask

  // Noise: runs of zeros, ones and random bytes, sometimes ending the stream
  task send_noise();
    logic [7:0] q[$];
    int pick;
    q = {};
    repeat ($urandom_range(1, 12)) begin
      pick = $urandom_range(9);
      if (pick < 4) q.push_back(ZERO_BYTE);
      else if (pick < 6) q.push_back(START_BYTE);
      else q.push_back(8'($urandom_range(255)));
    end
    send_run(q, $urandom_range(2) == 0);
  endtask

  initial begin
    tracker  = new();
    clk      = 1'b0;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tlast  = 1'b0;
    m_tready = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    bytes_sent = 0;
    cycle_count = 0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: a lone final byte, stream with no unit
    send_run('{8'hff}, 1'b1);
    // Junk before the first code, 4-byte and 3-byte codes, delimiter closing
    // a unit, delimiter with no unit open, final code with no header byte
    send_run('{8'hab, 8'h00, 8'h00, 8'h00, 8'h01, 8'h65,
               8'h00, 8'h00, 8'h01, 8'h41,
               8'h00, 8'h00, 8'h01, 8'h09, 8'hf0,
               8'h00, 8'h00, 8'h01, 8'h29,
               8'h00, 8'h00, 8'h01, 8'h67, 8'hff,
               8'h00, 8'h00, 8'h01}, 1'b1);
    drain();

    // Random phases: no idling, sender idle, receiver stall, both light
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 76; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 76; end
        default: begin idle_pct = 10; stall_pct = 10; end
      endcase
      while (bytes_sent < (ph + 1) * RUN_BYTES / 4) begin
        if ($urandom_range(9) == 0) send_noise();
        else send_stream();
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.owed() != 0) begin
      tracker.report("beats still owed", 32'(tracker.owed()), '0);
    end
    if (tracker.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
